@@ design/ascii_box_frame_parser_macros.svh @@
// ----------------------------------------------------------------------------
// ascii_box_frame_parser assertion macros
// Concurrent checks used by the frame parser RTL; empty bodies when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASCII_BOX_FRAME_PARSER_MACROS_SVH
`define ASCII_BOX_FRAME_PARSER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define ABFP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("abfp: implication check failed");
// next-cycle implication
`define ABFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("abfp: next-cycle check failed");
`else
`define ABFP_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ABFP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ design/abfp_pkg.sv @@
// ----------------------------------------------------------------------------
// abfp_pkg
// Shared types and constants of the ASCII box frame parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package abfp_pkg;

  localparam int MAX_FRAME_DEF = 62;

  localparam int BYTE_W   = 8;
  localparam int FIELD_W  = 16;
  localparam int CENTER_W = FIELD_W + 1;
  localparam int IMG_C_W  = 10;
  localparam int GAIN_W   = 8;
  localparam int OFF_W    = 19;

  // ASCII codes
  localparam logic [BYTE_W-1:0] CHAR_NUL    = 8'h00;
  localparam logic [BYTE_W-1:0] CHAR_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CHAR_HASH   = 8'h23;
  localparam logic [BYTE_W-1:0] CHAR_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE   = 8'h39;

  localparam logic [FIELD_W-1:0] FIELD_MAX = 16'hFFFF;

  localparam logic [IMG_C_W-1:0] IMG_CENTER_RESET = 10'd320;
  localparam logic [GAIN_W-1:0]  GAIN_RESET       = 8'd39;

  // divide by 100: x / 100 == (x * ceil(2^32 / 100)) >> 32 for x < 2^30
  localparam int MAG_W     = CENTER_W + GAIN_W;
  localparam int RECIP_W   = 26;
  localparam int DIV_SHIFT = 32;
  localparam int PROD_W    = MAG_W + RECIP_W;
  localparam logic [RECIP_W-1:0] DIV_RECIP = 26'd42949673;

  typedef struct packed {
    logic [FIELD_W-1:0] x;
    logic [FIELD_W-1:0] y;
    logic [FIELD_W-1:0] w;
    logic [FIELD_W-1:0] h;
  } box_t;

endpackage

@@ design/ascii_box_frame_parser.sv @@
// ----------------------------------------------------------------------------
// ascii_box_frame_parser
// Parses '$'..'#' ASCII box frames into a box, its center and a scaled offset.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while in_stall is low; a byte enters the input
//   register in each cycle with in_valid high and in_stall low.
// A result passes the input, box, multiply-by-gain and divide registers in order.
// The divide by 100 is a reciprocal multiply in its own stage.
// Reset (rst, synchronous): empties the pipeline, clears the frame state and
//   loads image_center = 320, gain_per_hundred = 39.
`timescale 1ns / 1ps

module ascii_box_frame_parser
  import abfp_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [BYTE_W-1:0]       rx_byte,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [FIELD_W-1:0]      box_x,
  output logic [FIELD_W-1:0]      box_y,
  output logic [FIELD_W-1:0]      box_w,
  output logic [FIELD_W-1:0]      box_h,
  output logic [CENTER_W-1:0]     center_x,
  output logic [CENTER_W-1:0]     center_y,
  output logic signed [OFF_W-1:0] offset_mm,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [7:0]              cfg_index,
  input  logic [IMG_C_W-1:0]      cfg_data
);

  localparam logic [7:0] CFG_IMAGE_CENTER = 8'd0;
  localparam logic [7:0] CFG_GAIN         = 8'd1;

  logic [IMG_C_W-1:0] image_center;
  logic [GAIN_W-1:0]  gain_per_hundred;

  logic frm_valid;
  logic frm_ready;
  box_t frm_box;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_center     <= IMG_CENTER_RESET;
      gain_per_hundred <= GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IMAGE_CENTER: image_center <= cfg_data;
        CFG_GAIN:         gain_per_hundred <= cfg_data[GAIN_W-1:0];
        default: begin
          // drop writes outside the register map
        end
      endcase
    end
  end

  abfp_parser #(
    .MAX_FRAME (MAX_FRAME)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .frm_valid (frm_valid),
    .frm_ready (frm_ready),
    .frm_box   (frm_box)
  );

  abfp_calc u_calc (
    .clk              (clk),
    .rst              (rst),
    .frm_valid        (frm_valid),
    .frm_ready        (frm_ready),
    .frm_box          (frm_box),
    .image_center     (image_center),
    .gain_per_hundred (gain_per_hundred),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .box_x            (box_x),
    .box_y            (box_y),
    .box_w            (box_w),
    .box_h            (box_h),
    .center_x         (center_x),
    .center_y         (center_y),
    .offset_mm        (offset_mm)
  );

endmodule

@@ design/abfp_parser.sv @@
// ----------------------------------------------------------------------------
// abfp_parser
// Byte input register and frame parsing state; hands a finished box downstream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ascii_box_frame_parser_macros.svh"

module abfp_parser
  import abfp_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic              frm_valid,
  input  logic              frm_ready,
  output box_t              frm_box
);

  localparam int CNT_W = $clog2(MAX_FRAME + 1);

  typedef enum logic [3:0] {
    PH_SEEK   = 4'b0001,
    PH_FIELDS = 4'b0010,
    PH_DONE   = 4'b0100,
    PH_DEAD   = 4'b1000
  } phase_t;

  logic              a_valid;
  logic [BYTE_W-1:0] a_byte;

  logic [CNT_W-1:0]   frame_count;
  phase_t             phase;
  logic [2:0]         field_num;
  logic [FIELD_W-1:0] vals [4];

  logic [CNT_W-1:0]   frame_count_next;
  phase_t             phase_next;
  logic [2:0]         field_num_next;
  logic [FIELD_W-1:0] vals_next [4];

  logic frame_end;
  logic had_dollar;
  logic a_fire;

  always_comb begin
    logic [1:0]         k;
    logic               is_digit;
    logic [3:0]         dig;
    logic [FIELD_W+3:0] acc;

    k        = field_num[1:0] + 2'd2;
    is_digit = (a_byte >= CHAR_ZERO) && (a_byte <= CHAR_NINE);
    dig      = 4'(a_byte - CHAR_ZERO);
    acc      = ({4'b0, vals[k]} << 3) + ({4'b0, vals[k]} << 1) + {16'b0, dig};

    phase_next     = phase;
    field_num_next = field_num;
    vals_next      = vals;

    case (phase)
      PH_SEEK: begin
        if (a_byte == CHAR_NUL) begin
          phase_next = PH_DEAD;
        end else if (a_byte == CHAR_DOLLAR) begin
          phase_next = PH_FIELDS;
        end
      end
      PH_FIELDS: begin
        if (a_byte == CHAR_NUL) begin
          phase_next = PH_DONE;
        end else if (is_digit) begin
          if (field_num >= 3'd2 && field_num <= 3'd5) begin
            vals_next[k] = (acc > {4'b0, FIELD_MAX}) ? FIELD_MAX : acc[FIELD_W-1:0];
          end
        end else begin
          field_num_next = field_num + 3'd1;
          if (field_num_next >= 3'd6) begin
            phase_next = PH_DONE;
          end
        end
      end
      default: begin
        // halted: ignore bytes until the frame ends
      end
    endcase

    frame_count_next = frame_count + CNT_W'(1);
    frame_end  = (a_byte == CHAR_HASH) || (frame_count_next >= CNT_W'(MAX_FRAME));
    had_dollar = (phase_next == PH_FIELDS) || (phase_next == PH_DONE);
  end

  assign frm_valid = a_valid && frame_end && had_dollar;
  assign frm_box   = '{x: vals_next[0], y: vals_next[1], w: vals_next[2], h: vals_next[3]};
  assign a_fire    = a_valid && (!(frame_end && had_dollar) || frm_ready);
  assign in_stall  = a_valid && !a_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      a_valid <= 1'b1;
    end else if (a_fire) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      a_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= '0;
      phase       <= PH_SEEK;
      field_num   <= '0;
      vals        <= '{default: '0};
    end else if (a_fire) begin
      if (frame_end) begin
        // clear for the next frame
        frame_count <= '0;
        phase       <= PH_SEEK;
        field_num   <= '0;
        vals        <= '{default: '0};
      end else begin
        frame_count <= frame_count_next;
        phase       <= phase_next;
        field_num   <= field_num_next;
        vals        <= vals_next;
      end
    end
  end

  `ABFP_ASSERT_IMPLY(a_count_bound, clk, rst, 1'b1, frame_count < CNT_W'(MAX_FRAME))
  `ABFP_ASSERT_IMPLY(a_seek_no_field, clk, rst, phase == PH_SEEK, field_num == 3'd0)
  `ABFP_ASSERT_IMPLY(a_fields_open, clk, rst, phase == PH_FIELDS, field_num < 3'd6)

endmodule

@@ design/abfp_calc.sv @@
// ----------------------------------------------------------------------------
// abfp_calc
// Box center and scaled offset pipeline with the result output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ascii_box_frame_parser_macros.svh"

module abfp_calc
  import abfp_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       frm_valid,
  output logic                       frm_ready,
  input  box_t                       frm_box,
  input  logic [IMG_C_W-1:0]         image_center,
  input  logic [GAIN_W-1:0]          gain_per_hundred,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [FIELD_W-1:0]         box_x,
  output logic [FIELD_W-1:0]         box_y,
  output logic [FIELD_W-1:0]         box_w,
  output logic [FIELD_W-1:0]         box_h,
  output logic [CENTER_W-1:0]        center_x,
  output logic [CENTER_W-1:0]        center_y,
  output logic signed [OFF_W-1:0]    offset_mm
);

  // stage B: parsed box
  logic b_valid;
  box_t b_box;

  // stage C: box, centers, offset magnitude before the divide
  logic                c_valid;
  box_t                c_box;
  logic [CENTER_W-1:0] c_cx;
  logic [CENTER_W-1:0] c_cy;
  logic [MAG_W-1:0]    c_mag;
  logic                c_neg;

  logic b_ready;
  logic c_ready;
  logic d_ready;

  logic [CENTER_W-1:0] cx;
  logic [CENTER_W-1:0] cy;
  logic [CENTER_W:0]   diff;
  logic [CENTER_W-1:0] abs_diff;
  logic [MAG_W-1:0]    mag;
  logic [PROD_W-1:0]   prod;
  logic [OFF_W-1:0]    quot;

  assign d_ready   = !out_valid || !out_stall;
  assign c_ready   = !c_valid || d_ready;
  assign b_ready   = !b_valid || c_ready;
  assign frm_ready = b_ready;

  assign cx       = {1'b0, b_box.x} + {2'b0, b_box.w[FIELD_W-1:1]};
  assign cy       = {1'b0, b_box.y} + {2'b0, b_box.h[FIELD_W-1:1]};
  assign diff     = {1'b0, cx} - {(CENTER_W + 1 - IMG_C_W)'(0), image_center};
  assign abs_diff = diff[CENTER_W] ? CENTER_W'(-diff) : diff[CENTER_W-1:0];
  assign mag      = {{GAIN_W{1'b0}}, abs_diff} * {{CENTER_W{1'b0}}, gain_per_hundred};

  assign prod = {{RECIP_W{1'b0}}, c_mag} * {{MAG_W{1'b0}}, DIV_RECIP};
  assign quot = prod[DIV_SHIFT +: OFF_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      b_valid   <= (b_valid && !c_ready) || (frm_valid && b_ready);
      c_valid   <= (c_valid && !d_ready) || (b_valid && c_ready);
      out_valid <= (out_valid && out_stall) || (c_valid && d_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (frm_valid && b_ready) begin
      b_box <= frm_box;
    end
    if (b_valid && c_ready) begin
      c_box <= b_box;
      c_cx  <= cx;
      c_cy  <= cy;
      c_mag <= mag;
      c_neg <= diff[CENTER_W];
    end
    if (c_valid && d_ready) begin
      box_x     <= c_box.x;
      box_y     <= c_box.y;
      box_w     <= c_box.w;
      box_h     <= c_box.h;
      center_x  <= c_cx;
      center_y  <= c_cy;
      // truncate toward zero: divide the magnitude, then restore the sign
      offset_mm <= c_neg ? $signed(OFF_W'(0) - quot) : $signed(quot);
    end
  end

  `ABFP_ASSERT_NEXT(a_c_hold, clk, rst, c_valid && !d_ready, c_valid)
  `ABFP_ASSERT_NEXT(a_out_drain, clk, rst, out_valid && !out_stall && !c_valid, !out_valid)

endmodule
